>>> sv/assert_macros.svh
// Assertion macros for the timed serial byte receiver.
// The files that check their own logic include this header. It has no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge that falls outside reset.
`define TSBR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tsbr assertion failed");
// The condition must never be true at a clock edge that falls outside reset.
`define TSBR_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tsbr forbidden condition seen");
`else
`define TSBR_ASSERT(label, clk, rst_n, prop)
`define TSBR_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> sv/tsbr_pkg.sv
// Shared constants and types for the timed serial byte receiver.
// It has no dependencies. The result and configuration interfaces, the top level and the testbench import it.
`default_nettype none

package tsbr_pkg;

    // Frame format and field widths.
    localparam int DATA_BITS = 8;
    localparam int IDX_W     = 4;
    localparam int TIMER_W   = 16;
    localparam int CORR_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [TIMER_W-1:0] BIT_PERIOD_RESET = TIMER_W'(104);
    localparam logic [CORR_W-1:0]  CORRECTION_RESET = CORR_W'(18);

    // Index of the last data bit, at the width of the bit counter.
    localparam logic [IDX_W-1:0]   LAST_BIT_IDX     = IDX_W'(DATA_BITS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_PERIOD  = 1'b0,
        REG_PERIOD_CORR = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> sv/tsbr_channels.sv
// Valid/ready channel interfaces for the timed serial byte receiver.
// The result and configuration interfaces depend on tsbr_pkg for field widths.
`default_nettype none

// Line sample channel: one item per microsecond tick.
interface tsbr_line_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

// Result channel: one item for every accepted line sample.
interface tsbr_result_if;
    import tsbr_pkg::*;
    logic              valid;
    logic              ready;
    logic              byte_done;
    logic [BYTE_W-1:0] received_byte;

    modport source (output valid, output byte_done, output received_byte, input ready);
    modport sink   (input valid, input byte_done, input received_byte, output ready);
endinterface

// Configuration write channel.
interface tsbr_cfg_if;
    import tsbr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/timed_serial_byte_receiver_top.sv
// Timed serial byte receiver: each accepted line sample gives one registered result item.
// Throughput is one item per cycle while results are taken; the bit timer, bit counter and shift
// register update in one pass. A new sample is taken while a result waits, as long as the result
// is taken in the same cycle. Reset (rst_n low, asynchronous) clears the timer, counter and bytes,
// sets the previous level high, and loads a bit period of 104 ticks and a correction of 18 ticks.
// Depends on tsbr_pkg, tsbr_channels and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module timed_serial_byte_receiver_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    tsbr_line_if.sink      line_in,
    tsbr_result_if.source  result_out,
    tsbr_cfg_if.sink       cfg
);
    import tsbr_pkg::*;

    // Configuration registers.
    logic [TIMER_W-1:0] bit_period_reg;
    logic [CORR_W-1:0]  period_corr_reg;

    // Receiver state.
    logic [TIMER_W-1:0] bit_timer_reg,  bit_timer_next;
    logic [IDX_W-1:0]   bit_index_reg,  bit_index_next;
    logic [BYTE_W-1:0]  shift_byte_reg, shift_byte_next;
    logic               prev_level_reg, prev_level_next;
    logic [BYTE_W-1:0]  held_byte_reg,  held_byte_next;

    // Result register.
    logic               out_valid_reg;
    logic               out_done_reg;
    logic [BYTE_W-1:0]  out_byte_reg;

    logic               in_accept;
    logic               out_accept;
    logic               done_next;
    logic [TIMER_W-1:0] timer_dec;
    logic [TIMER_W-1:0] corrected_period;
    logic               expired;
    logic [IDX_W-1:0]   bit_pos;
    logic [IDX_W-1:0]   index_inc;

    // Handshakes: the result register is free when empty or being emptied.
    assign cfg.ready         = 1'b1;
    assign out_accept        = out_valid_reg & result_out.ready;
    assign line_in.ready     = ~out_valid_reg | result_out.ready;
    assign in_accept         = line_in.valid & line_in.ready;

    assign result_out.valid         = out_valid_reg;
    assign result_out.byte_done     = out_done_reg;
    assign result_out.received_byte = out_byte_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= BIT_PERIOD_RESET;
            period_corr_reg <= CORRECTION_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BIT_PERIOD:  bit_period_reg  <= cfg.data;
                REG_PERIOD_CORR: period_corr_reg <= cfg.data[CORR_W-1:0];
                default:         ;
            endcase
        end
    end

    // Timer countdown with saturating reload value.
    always_comb
    begin
        timer_dec = (bit_timer_reg != '0) ? bit_timer_reg - TIMER_W'(1) : '0;
        expired   = (timer_dec == '0);
        if (TIMER_W'(period_corr_reg) >= bit_period_reg)
            corrected_period = '0;
        else
            corrected_period = bit_period_reg - TIMER_W'(period_corr_reg);
        bit_pos   = bit_index_reg - IDX_W'(1);
        index_inc = bit_index_reg + IDX_W'(1);
    end

    // Start detection while idle, one data bit per expiry while receiving.
    always_comb
    begin
        bit_timer_next  = expired ? corrected_period : timer_dec;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        prev_level_next = prev_level_reg;
        held_byte_next  = held_byte_reg;
        done_next       = 1'b0;

        if (bit_index_reg == '0)
        begin
            if (!line_in.line_level && prev_level_reg)
            begin
                bit_index_next = IDX_W'(1);
                bit_timer_next = bit_period_reg;
            end
            prev_level_next = line_in.line_level;
        end
        else if (expired)
        begin
            // Positions beyond the held byte are dropped.
            if (bit_pos < IDX_W'(BYTE_W))
                shift_byte_next = shift_byte_reg
                    | (BYTE_W'(line_in.line_level) << bit_pos[POS_W-1:0]);
            bit_index_next = index_inc;
            if (index_inc > LAST_BIT_IDX)
            begin
                held_byte_next  = shift_byte_next;
                shift_byte_next = '0;
                bit_index_next  = '0;
                done_next       = 1'b1;
            end
        end
    end

    // State update on each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_timer_reg  <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            prev_level_reg <= 1'b1;
            held_byte_reg  <= '0;
        end
        else if (in_accept)
        begin
            bit_timer_reg  <= bit_timer_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            prev_level_reg <= prev_level_next;
            held_byte_reg  <= held_byte_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_accept)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_done_reg <= done_next;
            out_byte_reg <= held_byte_next;
        end
    end

    // A new item never overwrites a result that is still waiting.
    `TSBR_NEVER(a_no_overwrite, clk, rst_n, in_accept && out_valid_reg && !result_out.ready)
    // The bit counter stays within the frame.
    `TSBR_NEVER(a_index_range, clk, rst_n, bit_index_reg > LAST_BIT_IDX)
    // A completed byte returns the receiver to idle and shows up in the result register.
    `TSBR_ASSERT(a_done_idle, clk, rst_n,
        (in_accept && done_next) |=> (bit_index_reg == '0 && out_valid_reg && out_done_reg))
    // Receiver state moves only when an item is accepted.
    `TSBR_ASSERT(a_state_hold, clk, rst_n,
        !in_accept |=> ($stable(bit_index_reg) && $stable(bit_timer_reg)))

endmodule

`default_nettype wire

>>> tb/sv/timed_serial_byte_receiver_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timed serial byte receiver: directed and random line samples,
// each one predicted tick by tick and compared with the result channel.
// Depends on tsbr_pkg, tsbr_channels and timed_serial_byte_receiver_top.

module timed_serial_byte_receiver_top_tb;
    import tsbr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned RANDOM_SAMPLES  = 1350;
    localparam int unsigned MIN_BYTES       = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned HOLD_OFF_AFTER  = 400;

    typedef struct packed {
        logic              byte_done;
        logic [BYTE_W-1:0] received_byte;
    } tick_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tsbr_line_if   line_if ();
    tsbr_result_if result_if ();
    tsbr_cfg_if    cfg_if ();

    timed_serial_byte_receiver_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (line_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // Free-running clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver state as the testbench expects it to be.
    logic [TIMER_W-1:0] rx_period     = BIT_PERIOD_RESET;
    logic [CORR_W-1:0]  rx_correction = CORRECTION_RESET;
    logic [TIMER_W-1:0] rx_timer      = '0;
    logic [IDX_W-1:0]   rx_bit_idx    = '0;
    logic [BYTE_W-1:0]  rx_shift      = '0;
    logic               rx_prev_level = 1'b1;
    logic [BYTE_W-1:0]  rx_held       = '0;

    logic         line_samples[$];
    tick_result_t expected_ticks[$];

    int unsigned samples_pushed  = 0;
    int unsigned samples_taken   = 0;
    int unsigned random_samples  = 0;
    int unsigned bytes_completed = 0;
    int unsigned mismatch_count  = 0;
    logic        line_taken      = 1'b0;

    int unsigned line_gap    = 0;
    int unsigned line_calm   = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_calm  = 0;
    int unsigned hold_left   = 0;
    logic        held_off    = 1'b0;

    // Advances the expected receiver by one line sample and returns the result of that tick.
    function automatic tick_result_t receive_tick(input logic level);
        logic             expired;
        logic [IDX_W-1:0] pos;
        tick_result_t     res;
        res.byte_done = 1'b0;
        if (rx_timer != '0)
            rx_timer = rx_timer - 1'b1;
        expired = (rx_timer == '0);
        if (expired)
            rx_timer = (TIMER_W'(rx_correction) >= rx_period) ? '0
                       : rx_period - TIMER_W'(rx_correction);
        if (rx_bit_idx == '0)
        begin
            // Idle: a falling edge starts a frame and loads the full bit period.
            if (!level && rx_prev_level)
            begin
                rx_bit_idx = IDX_W'(1);
                rx_timer   = rx_period;
            end
            rx_prev_level = level;
        end
        else if (expired)
        begin
            pos = rx_bit_idx - 1'b1;
            if (pos < IDX_W'(BYTE_W))
                rx_shift = rx_shift | (BYTE_W'(level) << pos);
            rx_bit_idx = rx_bit_idx + 1'b1;
            if (rx_bit_idx > LAST_BIT_IDX)
            begin
                rx_held       = rx_shift;
                rx_shift      = '0;
                rx_bit_idx    = '0;
                res.byte_done = 1'b1;
                bytes_completed++;
            end
        end
        res.received_byte = rx_held;
        return res;
    endfunction

    // Gap length before the next item or ready cycle: mostly short, a few long, with calm runs.
    function automatic int unsigned pick_gap(ref int unsigned calm_left);
        int unsigned roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic note_mismatch(input string what, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Rising edge: record accepted samples with their expected results, then check results.
    always @(posedge clk)
    begin
        tick_result_t want;
        line_taken = line_if.valid && line_if.ready;
        if (line_taken)
        begin
            expected_ticks.push_back(receive_tick(line_if.line_level));
            samples_taken++;
        end
        if (result_if.valid && result_if.ready)
        begin
            if (expected_ticks.size() == 0)
                note_mismatch("unexpected result item", '0, result_if.received_byte);
            else
            begin
                want = expected_ticks.pop_front();
                if (result_if.byte_done !== want.byte_done)
                    note_mismatch("byte_done", BYTE_W'(want.byte_done),
                                  BYTE_W'(result_if.byte_done));
                if (result_if.received_byte !== want.received_byte)
                    note_mismatch("received_byte", want.received_byte,
                                  result_if.received_byte);
            end
        end
    end

    // Line sample driver, fed from the queue of pending samples.
    always @(negedge clk)
    begin
        if (!rst_n)
            line_if.valid <= 1'b0;
        else if (!line_if.valid || line_taken)
        begin
            if (line_gap > 0)
            begin
                line_gap--;
                line_if.valid <= 1'b0;
            end
            else if (line_samples.size() != 0)
            begin
                line_if.valid      <= 1'b1;
                line_if.line_level <= line_samples.pop_front();
                line_gap = pick_gap(line_calm);
            end
            else
                line_if.valid <= 1'b0;
        end
    end

    // Result side: random stalls, and one long hold-off while samples are still being offered.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else if (!held_off && samples_taken >= HOLD_OFF_AFTER
                 && samples_pushed - samples_taken > 30)
        begin
            held_off  = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            result_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
            stall_left = pick_gap(stall_calm);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            REG_BIT_PERIOD:  rx_period     = value;
            REG_PERIOD_CORR: rx_correction = value[CORR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until every queued sample has been taken and every expected result has arrived.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (samples_taken != samples_pushed || expected_ticks.size() != 0);
    endtask

    task automatic push_level(input logic level, input int unsigned count);
        repeat (count)
        begin
            line_samples.push_back(level);
            samples_pushed++;
        end
    endtask

    // Start bit followed by the first nbits data bits, least significant first.
    task automatic queue_frame(input logic [BYTE_W-1:0] data, input int unsigned nbits,
                               input int unsigned start_len, input int unsigned bit_len);
        push_level(1'b0, start_len);
        for (int b = 0; b < nbits; b++)
            push_level(data[b], bit_len);
    endtask

    // One setting of the registers followed by frames, broken frames and line noise.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] period_word,
                             input logic [CFG_DATA_W-1:0] corr_word,
                             input int unsigned count);
        int unsigned first, stop_at, roll, eff_period, eff_bit, start_len;
        wait_idle();
        write_reg(REG_BIT_PERIOD, period_word);
        write_reg(REG_PERIOD_CORR, corr_word);
        eff_period = (rx_period == '0) ? 1 : rx_period;
        eff_bit    = (TIMER_W'(rx_correction) >= rx_period) ? 1
                     : rx_period - TIMER_W'(rx_correction);
        // Aim each data bit so that the bit timer expires near its middle.
        start_len  = (eff_period > eff_bit / 2 + 1) ? eff_period - eff_bit / 2 : 1;
        first      = samples_pushed;
        stop_at    = samples_pushed + count;
        while (samples_pushed < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                push_level(1'b1, $urandom_range(1, 3));
                queue_frame(BYTE_W'($urandom), BYTE_W, start_len, eff_bit);
                push_level(1'b1, eff_bit * $urandom_range(1, 2));
            end
            else if (roll < 88)
            begin
                push_level(1'b1, 1);
                queue_frame(BYTE_W'($urandom), $urandom_range(0, BYTE_W - 1), start_len,
                            eff_bit);
            end
            else
                repeat ($urandom_range(1, 12))
                    push_level(1'($urandom_range(0, 1)), 1);
        end
        random_samples += samples_pushed - first;
    endtask

    // Stimulus: reset, a directed frame pair, fixed corner settings, then random settings.
    initial
    begin
        int unsigned p, c, roll;
        rst_n              = 1'b0;
        line_if.valid      = 1'b0;
        line_if.line_level = 1'b1;
        result_if.ready    = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_BIT_PERIOD;
        cfg_if.data        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // One tick per bit: an all-ones byte, a low line right after it that must not start
        // a frame, then an all-zeros byte.
        write_reg(REG_BIT_PERIOD, CFG_DATA_W'(1));
        write_reg(REG_PERIOD_CORR, CFG_DATA_W'(0));
        push_level(1'b1, 1);
        queue_frame(8'hFF, BYTE_W, 1, 1);
        push_level(1'b0, 2);
        push_level(1'b1, 1);
        queue_frame(8'h00, BYTE_W, 1, 1);

        // Largest period with every data bit set; the line stays idle so no frame is pending.
        wait_idle();
        write_reg(REG_BIT_PERIOD, '1);
        write_reg(REG_PERIOD_CORR, '1);
        push_level(1'b1, 16);

        // Zero period, correction above the period, and the reset values.
        run_phase(CFG_DATA_W'(0), CFG_DATA_W'(0), 60);
        run_phase(CFG_DATA_W'(6), CFG_DATA_W'(9), 60);
        run_phase(CFG_DATA_W'(BIT_PERIOD_RESET), CFG_DATA_W'(CORRECTION_RESET), 120);

        while (random_samples < RANDOM_SAMPLES || bytes_completed < MIN_BYTES)
        begin
            p    = $urandom_range(1, 8);
            roll = $urandom_range(0, 99);
            if (roll < 8)
                p = 0;
            roll = $urandom_range(0, 99);
            if (p == 0)
                c = $urandom_range(0, 3);
            else if (roll < 65)
                c = $urandom_range(0, p - 1);
            else if (roll < 85)
                c = p + $urandom_range(0, 3);
            else
                c = 0;
            // Upper data bits of the correction write are random; the register keeps eight.
            run_phase(CFG_DATA_W'(p), {8'($urandom), 8'(c)}, $urandom_range(60, 140));
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_ticks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Ends the run if no item moves on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((line_if.valid && line_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/tsbr_pkg.sv
sv/tsbr_channels.sv
sv/timed_serial_byte_receiver_top.sv
tb/sv/timed_serial_byte_receiver_top_tb.sv
